>>> sv/rational_arith_unit_top_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef RATIONAL_ARITH_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_TOP_ASSERT_SVH

// ante true at a clock edge implies cons at the same edge
`define RAU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante true at a clock edge implies cons at the next edge
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rau_pkg.sv
package rau_pkg;

    localparam int OPERAND_BITS = 16;
    localparam int MAG_BITS     = OPERAND_BITS - 1;
    localparam int ACC_BITS_DEF = 32;
    localparam int RES_BITS     = 32;

    localparam logic [2:0] OP_LOAD = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_EQ   = 3'd3;
    localparam logic [2:0] OP_NE   = 3'd4;
    localparam logic [2:0] OP_ACC  = 3'd5;

    typedef struct packed {
        logic [2:0]                     opcode;
        logic signed [OPERAND_BITS-1:0] operand_num;
        logic signed [OPERAND_BITS-1:0] operand_den;
    } t_in_word;

    typedef struct packed {
        logic [RES_BITS-1:0] result_num;
        logic [RES_BITS-1:0] result_den;
        logic                result_empty;
        logic                compare_true;
        logic                overflow;
    } t_out_word;

endpackage

>>> sv/rau_reduce.sv
module rau_reduce #(
    parameter int MAG_BITS = rau_pkg::MAG_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MAG_BITS-1:0] i_num,
    input  logic [MAG_BITS-1:0] i_den,
    output logic                o_done,
    output logic [MAG_BITS-1:0] o_num,
    output logic [MAG_BITS-1:0] o_den
);

    localparam int KW = $clog2(MAG_BITS);

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_GCD  = 3'b010,
        R_DIV  = 3'b100
    } t_rstate;

    t_rstate             r_state, n_state;
    logic [MAG_BITS-1:0] r_a, n_a, r_b, n_b, r_g, n_g;
    logic [MAG_BITS-1:0] r_qn, n_qn, r_qd, n_qd, r_rn, n_rn, r_rd, n_rd;
    logic [KW-1:0]       r_k, n_k, r_cnt, n_cnt;
    logic                r_done, n_done;

    logic [MAG_BITS:0]   tn, td, gx;
    logic                ge_n, ge_d;

    // Binary gcd, then both values divided by it one quotient bit per cycle.
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_g     = r_g;
        n_qn    = r_qn;
        n_qd    = r_qd;
        n_rn    = r_rn;
        n_rd    = r_rd;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        gx      = {1'b0, r_g};
        tn      = {r_rn, r_qn[MAG_BITS-1]};
        td      = {r_rd, r_qd[MAG_BITS-1]};
        ge_n    = (tn >= gx);
        ge_d    = (td >= gx);
        case (r_state)
            R_IDLE: begin
                if (i_start) begin
                    n_a     = i_num;
                    n_b     = i_den;
                    n_qn    = i_num;
                    n_qd    = i_den;
                    n_k     = '0;
                    n_state = R_GCD;
                end
            end
            R_GCD: begin
                if (r_a == r_b) begin
                    n_g     = r_a << r_k;
                    n_rn    = '0;
                    n_rd    = '0;
                    n_cnt   = '0;
                    n_state = R_DIV;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a > r_b) begin
                    n_a = (r_a - r_b) >> 1;
                end else begin
                    n_b = (r_b - r_a) >> 1;
                end
            end
            R_DIV: begin
                n_rn = ge_n ? MAG_BITS'(tn - gx) : tn[MAG_BITS-1:0];
                n_rd = ge_d ? MAG_BITS'(td - gx) : td[MAG_BITS-1:0];
                n_qn = {r_qn[MAG_BITS-2:0], ge_n};
                n_qd = {r_qd[MAG_BITS-2:0], ge_d};
                if (r_cnt == KW'(MAG_BITS - 1)) begin
                    n_done  = 1'b1;
                    n_state = R_IDLE;
                end else begin
                    n_cnt = r_cnt + KW'(1);
                end
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_g   <= n_g;
        r_qn  <= n_qn;
        r_qd  <= n_qd;
        r_rn  <= n_rn;
        r_rd  <= n_rd;
        r_k   <= n_k;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_num  = r_qn;
    assign o_den  = r_qd;

endmodule

>>> sv/rational_arith_unit_top.sv
// Fraction arithmetic unit with an accumulator fraction.
// Input channel: i_in_valid / o_in_stall carry one word (opcode, operand
// numerator, operand denominator); a word is taken at an edge with valid high
// and stall low. Output channel: o_out_valid / i_out_stall carry one result
// word per input word, in order.
// Steps per word: it is taken, then operand reduction when the operand is not
// empty, its numerator is nonzero and the opcode is load to accumulate (binary
// gcd step by step, then bit-serial division of both values by the gcd, then a
// hand-over), then the cross products on one shared 32 x MAG_BITS multiplier, a
// 32-bit slice of the accumulator at a time (three products for add and
// accumulate, two for multiply and the compares, only when neither side is
// empty), then the result register is written. The next word is taken in the
// cycle after its result is written, and o_in_stall stays high the whole time.
// The output register holds a finished word while the receiver stalls; the
// next word is taken meanwhile, and its result waits until the register is
// free. The accumulator is updated in the cycle its result is written.
// Reset (i_rst_n low, synchronous) empties the accumulator, drops the output
// valid flag and lowers o_in_stall.
`include "rational_arith_unit_top_assert.svh"

module rational_arith_unit_top #(
    parameter int ACC_BITS = rau_pkg::ACC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rau_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rau_pkg::t_out_word o_out_word
);

    import rau_pkg::*;

    localparam int MW   = MAG_BITS;
    localparam int NCH  = (ACC_BITS + 31) / 32;
    localparam int PADW = NCH * 32;
    localparam int PW   = PADW + MW + 1;
    localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RED  = 4'b0010,
        S_MUL  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    typedef struct packed {
        logic last;
        logic src_den;
        logic opd_den;
        logic dst_b;
    } t_job;

    // add/acc: A = num*od + den*on, B = den*od
    // mul:     A = num*on,          B = den*od
    // eq/ne:   A = num*od,          B = den*on
    function automatic t_job job_of(input logic [2:0] op, input logic [1:0] idx);
        t_job j;
        if (op == OP_ADD || op == OP_ACC) begin
            if (idx == 2'd0)      j = '{last: 1'b0, src_den: 1'b0, opd_den: 1'b1, dst_b: 1'b0};
            else if (idx == 2'd1) j = '{last: 1'b0, src_den: 1'b1, opd_den: 1'b0, dst_b: 1'b0};
            else                  j = '{last: 1'b1, src_den: 1'b1, opd_den: 1'b1, dst_b: 1'b1};
        end else if (op == OP_MUL) begin
            if (idx == 2'd0)      j = '{last: 1'b0, src_den: 1'b0, opd_den: 1'b0, dst_b: 1'b0};
            else                  j = '{last: 1'b1, src_den: 1'b1, opd_den: 1'b1, dst_b: 1'b1};
        end else begin
            if (idx == 2'd0)      j = '{last: 1'b0, src_den: 1'b0, opd_den: 1'b1, dst_b: 1'b0};
            else                  j = '{last: 1'b1, src_den: 1'b1, opd_den: 1'b0, dst_b: 1'b1};
        end
        return j;
    endfunction

    function automatic logic need_mul(input logic [2:0] op, input logic op_empty,
                                      input logic acc_empty);
        return !op_empty && !acc_empty && (op inside {OP_ADD, OP_MUL, OP_EQ, OP_NE, OP_ACC});
    endfunction

    t_state                r_state, n_state;
    logic [2:0]            r_op, n_op;
    logic                  r_op_empty, n_op_empty;
    logic [MW-1:0]         r_on, n_on, r_od, n_od;
    logic [ACC_BITS-1:0]   r_acc_num, n_acc_num, r_acc_den, n_acc_den;
    logic                  r_acc_empty, n_acc_empty;
    logic [PW-1:0]         r_pa, n_pa, r_pb, n_pb;
    logic [1:0]            r_job, n_job;
    logic [CW-1:0]         r_chunk, n_chunk;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out_word;

    logic                  in_accept, in_empty, in_need_red, in_need_mul;
    logic                  red_done;
    logic [MW-1:0]         red_num, red_den;

    t_job                  job;
    logic [PADW-1:0]       src_pad;
    logic [31:0]           chunk_val;
    logic [MW-1:0]         opd;
    logic [32+MW-1:0]      prod;
    logic [PW-1:0]         addend, dst_sum;
    logic                  chunk_last;

    logic [PADW-1:0]       acc_num_pad, acc_den_pad;
    logic                  both, pa_ovf, pb_ovf, on_fit, od_fit;
    logic                  res_empty, res_cmp, res_ovf;
    logic [RES_BITS-1:0]   res_num, res_den;
    logic                  acc_wr, commit;
    logic [ACC_BITS-1:0]   acc_wr_num, acc_wr_den;
    logic                  acc_wr_empty;
    t_out_word             out_word;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_empty    = i_in_word.operand_num[OPERAND_BITS-1]
                       | i_in_word.operand_den[OPERAND_BITS-1]
                       | (i_in_word.operand_den == '0);
    assign in_need_red = !in_empty && (i_in_word.operand_num != '0)
                       && (i_in_word.opcode inside {[OP_LOAD:OP_ACC]});
    assign in_need_mul = need_mul(i_in_word.opcode, in_empty, r_acc_empty);

    rau_reduce #(
        .MAG_BITS (MW)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept && in_need_red),
        .i_num   (i_in_word.operand_num[MW-1:0]),
        .i_den   (i_in_word.operand_den[MW-1:0]),
        .o_done  (red_done),
        .o_num   (red_num),
        .o_den   (red_den)
    );

    // shared multiplier: one 32-bit accumulator slice per cycle
    assign job        = job_of(r_op, r_job);
    assign src_pad    = job.src_den ? PADW'(r_acc_den) : PADW'(r_acc_num);
    assign chunk_val  = 32'(src_pad >> {r_chunk, 5'b0});
    assign opd        = job.opd_den ? r_od : r_on;
    assign prod       = (32 + MW)'(chunk_val) * (32 + MW)'(opd);
    assign addend     = PW'(prod) << {r_chunk, 5'b0};
    assign dst_sum    = (job.dst_b ? r_pb : r_pa) + addend;
    assign chunk_last = (r_chunk == CW'(NCH - 1));

    assign acc_num_pad = PADW'(r_acc_num);
    assign acc_den_pad = PADW'(r_acc_den);
    assign both        = !r_op_empty && !r_acc_empty;
    assign pa_ovf      = (r_pa >> ACC_BITS) != '0;
    assign pb_ovf      = (r_pb >> ACC_BITS) != '0;
    assign on_fit      = (r_on >> ACC_BITS) == '0;
    assign od_fit      = (r_od >> ACC_BITS) == '0;
    assign commit      = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        res_empty    = r_acc_empty;
        res_num      = acc_num_pad[RES_BITS-1:0];
        res_den      = acc_den_pad[RES_BITS-1:0];
        res_cmp      = 1'b0;
        res_ovf      = 1'b0;
        acc_wr       = 1'b0;
        acc_wr_num   = r_acc_num;
        acc_wr_den   = r_acc_den;
        acc_wr_empty = r_acc_empty;
        case (r_op)
            OP_LOAD: begin
                if (r_op_empty) begin
                    acc_wr       = 1'b1;
                    acc_wr_num   = '0;
                    acc_wr_den   = '0;
                    acc_wr_empty = 1'b1;
                    res_empty    = 1'b1;
                end else if (!on_fit || !od_fit) begin
                    res_empty = 1'b1;
                    res_ovf   = 1'b1;
                end else begin
                    acc_wr       = 1'b1;
                    acc_wr_num   = ACC_BITS'(r_on);
                    acc_wr_den   = ACC_BITS'(r_od);
                    acc_wr_empty = 1'b0;
                    res_empty    = 1'b0;
                    res_num      = RES_BITS'(r_on);
                    res_den      = RES_BITS'(r_od);
                end
            end
            OP_ADD, OP_MUL, OP_ACC: begin
                if (!both) begin
                    res_empty = 1'b1;
                end else if (pa_ovf || pb_ovf) begin
                    res_empty = 1'b1;
                    res_ovf   = 1'b1;
                end else begin
                    res_empty = 1'b0;
                    res_num   = r_pa[RES_BITS-1:0];
                    res_den   = r_pb[RES_BITS-1:0];
                    if (r_op == OP_ACC) begin
                        acc_wr     = 1'b1;
                        acc_wr_num = r_pa[ACC_BITS-1:0];
                        acc_wr_den = r_pb[ACC_BITS-1:0];
                    end
                end
            end
            OP_EQ: begin
                res_cmp = both && (r_pa == r_pb);
            end
            OP_NE: begin
                res_cmp = both && (r_pa != r_pb);
            end
            default: begin
            end
        endcase
        out_word.result_num   = res_empty ? '0 : res_num;
        out_word.result_den   = res_empty ? '0 : res_den;
        out_word.result_empty = res_empty;
        out_word.compare_true = res_cmp;
        out_word.overflow     = res_ovf;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_op_empty  = r_op_empty;
        n_on        = r_on;
        n_od        = r_od;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_job       = r_job;
        n_chunk     = r_chunk;
        n_out_valid = commit ? 1'b1 : (r_out_valid && i_out_stall);
        n_acc_num   = (commit && acc_wr) ? acc_wr_num : r_acc_num;
        n_acc_den   = (commit && acc_wr) ? acc_wr_den : r_acc_den;
        n_acc_empty = (commit && acc_wr) ? acc_wr_empty : r_acc_empty;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op       = i_in_word.opcode;
                    n_op_empty = in_empty;
                    n_on       = i_in_word.operand_num[MW-1:0];
                    n_od       = i_in_word.operand_den[MW-1:0];
                    n_pa       = '0;
                    n_pb       = '0;
                    n_job      = '0;
                    n_chunk    = '0;
                    if (in_need_red)      n_state = S_RED;
                    else if (in_need_mul) n_state = S_MUL;
                    else                  n_state = S_DONE;
                end
            end
            S_RED: begin
                if (red_done) begin
                    n_on    = red_num;
                    n_od    = red_den;
                    n_state = need_mul(r_op, r_op_empty, r_acc_empty) ? S_MUL : S_DONE;
                end
            end
            S_MUL: begin
                if (job.dst_b) n_pb = dst_sum;
                else           n_pa = dst_sum;
                if (chunk_last) begin
                    n_chunk = '0;
                    if (job.last) n_state = S_DONE;
                    else          n_job   = r_job + 2'd1;
                end else begin
                    n_chunk = r_chunk + CW'(1);
                end
            end
            S_DONE: begin
                if (commit) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc_num   <= '0;
            r_acc_den   <= '0;
            r_acc_empty <= 1'b1;
            r_job       <= '0;
            r_chunk     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_acc_num   <= n_acc_num;
            r_acc_den   <= n_acc_den;
            r_acc_empty <= n_acc_empty;
            r_job       <= n_job;
            r_chunk     <= n_chunk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_op_empty <= n_op_empty;
        r_on       <= n_on;
        r_od       <= n_od;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        if (commit) begin
            r_out_word <= out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `RAU_ASSERT_NEXT(a_acc_hold, i_clk, i_rst_n, i_rst_n && !commit,
        $stable(r_acc_num) && $stable(r_acc_den) && $stable(r_acc_empty),
        "accumulator changed without a result write")
    `RAU_ASSERT_IMPL(a_mul_sides, i_clk, i_rst_n, r_state == S_MUL,
        !r_op_empty && !r_acc_empty, "products started with an empty side")
    `RAU_ASSERT_IMPL(a_red_done, i_clk, i_rst_n, red_done, r_state == S_RED,
        "reduction finished outside its wait state")
    `RAU_ASSERT_IMPL(a_out_rise, i_clk, i_rst_n, $rose(o_out_valid),
        $past(r_state == S_DONE), "output valid rose without a finished word")

endmodule

>>> sim/tb_rational_arith_unit_top.sv
module tb_rational_arith_unit_top;
    import rau_pkg::*;

    localparam int ACC_W          = ACC_BITS_DEF;
    localparam int QUIET_TAIL     = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_WORDS   = 1600;

    // opcodes with no operation behind them
    localparam logic [2:0] OP_RSV6 = 3'd6;
    localparam logic [2:0] OP_RSV7 = 3'd7;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_stall = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_word  o_out_word;

    t_in_word   pending_words[$];
    t_out_word  expected_results[$];

    // predicted accumulator fraction
    logic [127:0] acc_num_q   = '0;
    logic [127:0] acc_den_q   = '0;
    logic         acc_empty_q = 1'b1;

    int fail_count    = 0;
    int idle_cycles   = 0;
    int words_taken   = 0;
    int results_seen  = 0;
    int in_gap        = 0;
    int out_gap       = 0;
    int in_idle_pct   = 20;
    int out_idle_pct  = 4;

    rational_arith_unit_top #(
        .ACC_BITS(ACC_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic fits_acc(logic [127:0] v);
        return (v >> ACC_W) == 0;
    endfunction

    function automatic t_out_word frac_word(logic empty, logic [127:0] num,
                                            logic [127:0] den, logic cmp, logic ovf);
        t_out_word w;
        w.result_num   = empty ? '0 : num[RES_BITS-1:0];
        w.result_den   = empty ? '0 : den[RES_BITS-1:0];
        w.result_empty = empty;
        w.compare_true = cmp;
        w.overflow     = ovf;
        return w;
    endfunction

    // computes the result word of one input word and updates the accumulator
    function automatic t_out_word fraction_result(t_in_word w);
        logic [127:0] on, od, a, b, t, n, d;
        logic         op_empty, both, eq;
        t_out_word    r;
        on = {112'd0, w.operand_num};
        od = {112'd0, w.operand_den};
        op_empty = w.operand_num[OPERAND_BITS-1] || w.operand_den[OPERAND_BITS-1] || od == 0;
        both = !op_empty && !acc_empty_q;
        if (!op_empty && on != 0) begin
            a = on;
            b = od;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            on = on / a;
            od = od / a;
        end
        r = frac_word(acc_empty_q, acc_num_q, acc_den_q, 1'b0, 1'b0);
        case (w.opcode)
            OP_LOAD: begin
                if (op_empty) begin
                    acc_num_q   = '0;
                    acc_den_q   = '0;
                    acc_empty_q = 1'b1;
                    r = frac_word(1'b1, '0, '0, 1'b0, 1'b0);
                end else if (!fits_acc(on) || !fits_acc(od)) begin
                    r = frac_word(1'b1, '0, '0, 1'b0, 1'b1);
                end else begin
                    acc_num_q   = on;
                    acc_den_q   = od;
                    acc_empty_q = 1'b0;
                    r = frac_word(1'b0, on, od, 1'b0, 1'b0);
                end
            end
            OP_ADD, OP_ACC, OP_MUL: begin
                if (w.opcode == OP_MUL) begin
                    n = acc_num_q * on;
                end else begin
                    n = acc_num_q * od + on * acc_den_q;
                end
                d = acc_den_q * od;
                if (!both) begin
                    r = frac_word(1'b1, '0, '0, 1'b0, 1'b0);
                end else if (!fits_acc(n) || !fits_acc(d)) begin
                    r = frac_word(1'b1, '0, '0, 1'b0, 1'b1);
                end else begin
                    if (w.opcode == OP_ACC) begin
                        acc_num_q = n;
                        acc_den_q = d;
                    end
                    r = frac_word(1'b0, n, d, 1'b0, 1'b0);
                end
            end
            OP_EQ, OP_NE: begin
                n  = acc_num_q * od;
                d  = acc_den_q * on;
                eq = (n == d);
                if (both) begin
                    r.compare_true = (w.opcode == OP_EQ) ? eq : !eq;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_word(logic [2:0] op, int num, int den);
        t_in_word w;
        w.opcode      = op;
        w.operand_num = num[OPERAND_BITS-1:0];
        w.operand_den = den[OPERAND_BITS-1:0];
        pending_words.push_back(w);
    endtask

    function automatic int rand_value(bit want_den);
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 12);
            1: v = $urandom_range(0, 255);
            2: v = $urandom_range(0, 32767);
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 1;
                    2: v = 16384;
                    default: v = 32767;
                endcase
            end
        endcase
        if (want_den && v == 0) begin
            v = 1;
        end
        return v;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // input driver
    always @(posedge i_clk) begin : drive_in
        logic take;
        take = i_in_valid && !o_in_stall;
        if (take) begin
            expected_results.push_back(fraction_result(i_in_word));
            words_taken++;
            if (words_taken % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: in_idle_pct = 0;
                    1: in_idle_pct = 15;
                    default: in_idle_pct = 40;
                endcase
            end
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !take) begin
            i_in_valid <= 1'b1;
        end else if (in_gap > 0) begin
            in_gap--;
            i_in_valid <= 1'b0;
        end else if (pending_words.size() > QUIET_TAIL &&
                     $urandom_range(0, 99) < in_idle_pct) begin
            in_gap = $urandom_range(0, 18);
            i_in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            i_in_word  <= pending_words.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin : watch_out
        t_out_word exp_w;
        if (o_out_valid && !i_out_stall) begin
            results_seen++;
            if (results_seen % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: out_idle_pct = 0;
                    1: out_idle_pct = 3;
                    default: out_idle_pct = 10;
                endcase
            end
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected: %p", o_out_word);
                fail_count++;
            end else begin
                exp_w = expected_results.pop_front();
                check_field("result_num", exp_w.result_num, o_out_word.result_num);
                check_field("result_den", exp_w.result_den, o_out_word.result_den);
                check_field("result_empty", 32'(exp_w.result_empty),
                            32'(o_out_word.result_empty));
                check_field("compare_true", 32'(exp_w.compare_true),
                            32'(o_out_word.compare_true));
                check_field("overflow", 32'(exp_w.overflow), 32'(o_out_word.overflow));
            end
        end
        if (!i_rst_n || pending_words.size() <= QUIET_TAIL) begin
            out_gap = 0;
            i_out_stall <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < out_idle_pct) begin
            out_gap = $urandom_range(0, 18);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         a, b, k, len, num, den;
        logic [2:0] op;

        // empty accumulator after reset
        add_word(OP_ADD, 1, 2);
        add_word(OP_EQ, 1, 2);
        add_word(OP_RSV6, 3, 4);
        // zero numerator stays unreduced
        add_word(OP_LOAD, 0, 6);
        add_word(OP_ADD, 3, 9);
        add_word(OP_EQ, 0, 1);
        add_word(OP_LOAD, 30000, 12);
        add_word(OP_MUL, 32767, 32767);
        add_word(OP_NE, 5000, 2);
        add_word(OP_EQ, 5000, 2);
        // empty operands
        add_word(OP_LOAD, -5, 3);
        add_word(OP_MUL, 1, 1);
        add_word(OP_LOAD, 7, 0);
        add_word(OP_LOAD, 7, -3);
        add_word(OP_LOAD, -32768, -32768);
        add_word(OP_LOAD, 32767, 1);
        add_word(OP_ACC, 0, 32767);
        // overflow on accumulate and multiply
        add_word(OP_LOAD, 1, 32749);
        add_word(OP_ACC, 1, 32719);
        add_word(OP_ACC, 1, 32717);
        add_word(OP_MUL, 2, 32767);
        add_word(OP_RSV7, 0, 0);
        add_word(OP_NE, 1, 3);
        add_word(OP_ACC, -1, 5);

        while (pending_words.size() < RANDOM_WORDS) begin
            a = rand_value(1'b0);
            b = rand_value(1'b1);
            add_word(OP_LOAD, a, b);
            len = $urandom_range(1, 7);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 99) < 4) begin
                    add_word(3'($urandom_range(0, 7)), $urandom_range(0, 65535),
                             $urandom_range(0, 65535));
                    continue;
                end
                case ($urandom_range(0, 19))
                    0, 1, 2, 3:        op = OP_ADD;
                    4, 5, 6, 7:        op = OP_MUL;
                    8, 9, 10:          op = OP_EQ;
                    11, 12, 13:        op = OP_NE;
                    14, 15, 16, 17, 18: op = OP_ACC;
                    default:           op = $urandom_range(0, 1) ? OP_RSV6 : OP_RSV7;
                endcase
                num = rand_value(1'b0);
                den = rand_value(1'b1);
                k = $urandom_range(1, 4);
                if ((op == OP_EQ || op == OP_NE) && $urandom_range(0, 1) &&
                    a * k <= 32767 && b * k <= 32767) begin
                    num = a * k;
                    den = b * k;
                end else if ($urandom_range(0, 99) < 6) begin
                    case ($urandom_range(0, 2))
                        0: num = -$urandom_range(1, 32768);
                        1: den = 0;
                        default: den = -$urandom_range(1, 32768);
                    endcase
                end
                add_word(op, num, den);
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> rational_arith_unit_top.f
+incdir+sv
sv/rau_pkg.sv
sv/rau_reduce.sv
sv/rational_arith_unit_top.sv
sim/tb_rational_arith_unit_top.sv
